### src/cbm_pkg.sv
// ============================================================================
// cbm_pkg
// Shared types and constants for the cartridge bank mapper with clock.
// ============================================================================
`default_nettype none

package cbm_pkg;

    // Default size of the internal banked cartridge RAM, in bytes (a power of two).
    localparam int RAM_BYTES_DEF = 32768;

    // Depth of the result queue in front of the response port.
    localparam int OUTQ_DEPTH = 3;

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] CFG_ROM_SIZE = 2'd0;
    localparam logic [1:0] CFG_RAM_SIZE = 2'd1;
    localparam logic [1:0] CFG_RTC      = 2'd2;

    localparam logic [4:0] ROM_LOG2_MAX = 5'd21;

    // Cartridge RAM size codes.
    localparam logic [2:0] RAM_CODE_2K  = 3'd1;
    localparam logic [2:0] RAM_CODE_8K  = 3'd2;
    localparam logic [2:0] RAM_CODE_32K = 3'd3;
    localparam logic [2:0] RAM_CODE_64K = 3'd4;

    // Clock register selects, counted from select 8.
    localparam logic [2:0] RTC_SEC  = 3'd0;
    localparam logic [2:0] RTC_MIN  = 3'd1;
    localparam logic [2:0] RTC_HOUR = 3'd2;
    localparam logic [2:0] RTC_DAYL = 3'd3;
    localparam logic [2:0] RTC_DAYH = 3'd4;

    localparam logic [7:0] RTC_SEL_LAST = 8'd12;
    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [7:0] BYTE_OPEN    = 8'hFF;

    // Control register regions, taken from address bits 14:13.
    localparam logic [1:0] CTL_RAM_EN   = 2'd0;
    localparam logic [1:0] CTL_ROM_BANK = 2'd1;
    localparam logic [1:0] CTL_RAM_BANK = 2'd2;
    localparam logic [1:0] CTL_LATCH    = 2'd3;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_read;
        logic [20:0] rom_offset;
    } rsp_t;

    // Clock commands from the request decoder.
    typedef struct packed {
        logic       tick;
        logic       reg_wr;
        logic       latch_wr;
        logic [2:0] sel;
        logic [7:0] wdata;
    } rtc_cmd_t;

endpackage

`default_nettype wire

### src/cbm_ram.sv
// ============================================================================
// cbm_ram
// Single-port byte memory with a registered read, holding cartridge RAM.
// ============================================================================
`default_nettype none

module cbm_ram
    import cbm_pkg::*;
#(
    parameter int DEPTH = RAM_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### src/cbm_rtc.sv
// ============================================================================
// cbm_rtc
// Real-time clock counters, halt and carry flags, and the latched copy.
// ============================================================================
`default_nettype none

module cbm_rtc
    import cbm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire rtc_cmd_t cmd,
    output logic [7:0]    rd_byte
);

    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [8:0] day_reg, day_next;
    logic       halt_reg, halt_next;
    logic       carry_reg, carry_next;
    logic       latch_prev_reg, latch_prev_next;
    logic [7:0] latched_reg [5];
    logic       do_latch;

    logic [6:0] sec_inc, min_inc;
    logic [5:0] hour_inc;
    logic [9:0] day_inc;
    logic       c_sec, c_min, c_hour;

    // One-second advance as a mixed-radix carry chain; every stage carries at most one.
    always_comb
    begin
        sec_inc  = {1'b0, sec_reg} + 7'd1;
        c_sec    = (sec_inc >= 7'd60);
        min_inc  = {1'b0, min_reg} + {6'd0, c_sec};
        c_min    = (min_inc >= 7'd60);
        hour_inc = {1'b0, hour_reg} + {5'd0, c_min};
        c_hour   = (hour_inc >= 6'd24);
        day_inc  = {1'b0, day_reg} + {9'd0, c_hour};
    end

    always_comb
    begin
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        halt_next       = halt_reg;
        carry_next      = carry_reg;
        latch_prev_next = latch_prev_reg;
        do_latch        = 1'b0;
        if (cmd.tick && !halt_reg)
        begin
            sec_next   = c_sec  ? 6'(sec_inc - 7'd60)  : sec_inc[5:0];
            min_next   = c_min  ? 6'(min_inc - 7'd60)  : min_inc[5:0];
            hour_next  = c_hour ? 5'(hour_inc - 6'd24) : hour_inc[4:0];
            day_next   = day_inc[8:0];
            carry_next = carry_reg | day_inc[9];
        end
        if (cmd.reg_wr)
        begin
            unique case (cmd.sel)
                RTC_SEC:  sec_next  = cmd.wdata[5:0];
                RTC_MIN:  min_next  = cmd.wdata[5:0];
                RTC_HOUR: hour_next = cmd.wdata[4:0];
                RTC_DAYL: day_next  = {day_reg[8], cmd.wdata};
                RTC_DAYH:
                begin
                    day_next   = {cmd.wdata[0], day_reg[7:0]};
                    halt_next  = cmd.wdata[6];
                    carry_next = cmd.wdata[7];
                end
                default: ;
            endcase
        end
        if (cmd.latch_wr)
        begin
            do_latch        = !latch_prev_reg && cmd.wdata[0];
            latch_prev_next = cmd.wdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            day_reg        <= '0;
            halt_reg       <= 1'b0;
            carry_reg      <= 1'b0;
            latch_prev_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                latched_reg[i] <= '0;
            end
        end
        else
        begin
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            day_reg        <= day_next;
            halt_reg       <= halt_next;
            carry_reg      <= carry_next;
            latch_prev_reg <= latch_prev_next;
            if (do_latch)
            begin
                latched_reg[RTC_SEC]  <= {2'b00, sec_reg};
                latched_reg[RTC_MIN]  <= {2'b00, min_reg};
                latched_reg[RTC_HOUR] <= {3'b000, hour_reg};
                latched_reg[RTC_DAYL] <= day_reg[7:0];
                latched_reg[RTC_DAYH] <= {carry_reg, halt_reg, 5'b00000, day_reg[8]};
            end
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            RTC_SEC:  rd_byte = latched_reg[RTC_SEC];
            RTC_MIN:  rd_byte = latched_reg[RTC_MIN];
            RTC_HOUR: rd_byte = latched_reg[RTC_HOUR];
            RTC_DAYL: rd_byte = latched_reg[RTC_DAYL];
            RTC_DAYH: rd_byte = latched_reg[RTC_DAYH];
            default:  rd_byte = BYTE_OPEN;
        endcase
    end

endmodule

`default_nettype wire

### src/cbm_outq.sv
// ============================================================================
// cbm_outq
// Small result queue that decouples the response port from the pipeline.
// ============================================================================
`default_nettype none

module cbm_outq
    import cbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire rsp_t push_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp,
    output logic [$clog2(OUTQ_DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(OUTQ_DEPTH - 1);

    rsp_t          entry_reg [OUTQ_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign rsp_valid = (count_reg != '0);
    assign rsp       = entry_reg[head_reg];
    assign count     = count_reg;
    assign pop       = rsp_valid && !rsp_stall;

    always_comb
    begin
        head_next  = pop  ? ((head_reg == PTR_LAST) ? '0 : head_reg + 1'b1) : head_reg;
        tail_next  = push ? ((tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1) : tail_reg;
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### src/cartridge_bank_mapper_with_rtc.sv
// ============================================================================
// cartridge_bank_mapper_with_rtc
// Banked ROM/RAM mapper with a real-time clock, one bus request per cycle when not stalled.
// ============================================================================
// Path: an accepted request is held in the flight register, then pushed into the
// result queue; its response shows once the queue holds nothing older.
// Throughput: one request per cycle while req_stall stays low; each request makes at most one
// access to the single-port cartridge RAM, which sets that figure.
// Reset: rst_n clears all control, mapper and clock state at once; the cartridge RAM
// is not cleared and there is no startup pass, so requests are taken right after reset.
`default_nettype none

module cartridge_bank_mapper_with_rtc
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_t                  req,
    // response channel
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_t                       rsp,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    // A request in flight between the decode and the result queue. When use_mem is set
    // the read data comes from the RAM read register instead of res.read_data.
    typedef struct packed {
        logic use_mem;
        rsp_t res;
    } flight_t;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are taken in the access phase; pready is
    // tied high so every transfer completes without wait states.
    // ------------------------------------------------------------------
    logic [4:0] rom_size_reg;
    logic [2:0] ram_code_reg;
    logic       rtc_present_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg    <= ROM_LOG2_MAX;
            ram_code_reg    <= RAM_CODE_32K;
            rtc_present_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                CFG_ROM_SIZE: rom_size_reg    <= pwdata[4:0];
                CFG_RAM_SIZE: ram_code_reg    <= pwdata[2:0];
                CFG_RTC:      rtc_present_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_ROM_SIZE: prdata = {27'd0, rom_size_reg};
            CFG_RAM_SIZE: prdata = {29'd0, ram_code_reg};
            CFG_RTC:      prdata = {31'd0, rtc_present_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Mapper control registers.
    // ------------------------------------------------------------------
    logic       ram_en_reg, ram_en_next;
    logic [6:0] rom_sel_reg, rom_sel_next;
    logic [7:0] ram_sel_reg, ram_sel_next;

    // ------------------------------------------------------------------
    // Decode stage. Everything a request changes is committed at the edge that
    // accepts it, including the RAM write, so the next request already sees it;
    // a RAM read right after a write to the same byte therefore needs no bypass.
    // ------------------------------------------------------------------
    logic          acc;
    logic          is_rd, is_wr, is_tick;
    logic          in_rom, in_ram;
    logic          bank_is_clock, clock_ok, ram_none;
    logic [16:0]   code_size, ram_size;
    logic [15:0]   ram_mask, ram_off;
    logic [AW-1:0] ram_addr;
    logic          mem_we, mem_re;
    logic [7:0]    mem_rdata;
    logic [4:0]    rom_lg;
    logic [6:0]    rom_sel_eff;
    logic [21:0]   rom_mask;
    logic [20:0]   rom_raw;
    rtc_cmd_t      rtc_cmd;
    logic [7:0]    rtc_byte;
    flight_t       dec;

    logic          fl_valid_reg;
    flight_t       fl_reg;
    logic [CW-1:0] q_count;
    rsp_t          q_push_data;

    assign acc     = req_valid && !req_stall;
    assign is_rd   = (req.mode == MODE_READ);
    assign is_wr   = (req.mode == MODE_WRITE);
    assign is_tick = (req.mode == MODE_TICK);
    assign in_rom  = !req.address[15];
    assign in_ram  = (req.address[15:13] == 3'b101);

    // Selects 8 and up never reach RAM; only 8 to 12 are clock registers.
    assign bank_is_clock = |ram_sel_reg[7:3];
    assign clock_ok      = rtc_present_reg && (ram_sel_reg <= RTC_SEL_LAST);

    // Usable RAM size is the configured size capped at the built memory; all sizes
    // are powers of two, so wrapping is a mask.
    always_comb
    begin
        unique case (ram_code_reg)
            RAM_CODE_2K:  code_size = 17'd2048;
            RAM_CODE_8K:  code_size = 17'd8192;
            RAM_CODE_32K: code_size = 17'd32768;
            RAM_CODE_64K: code_size = 17'd65536;
            default:      code_size = 17'd0;
        endcase
        ram_size = (code_size > 17'(RAM_BYTES)) ? 17'(RAM_BYTES) : code_size;
    end

    assign ram_none = (ram_size == 17'd0);
    assign ram_mask = 16'(ram_size - 17'd1);
    assign ram_off  = {ram_sel_reg[2:0], req.address[12:0]};
    assign ram_addr = AW'(ram_off & ram_mask);

    assign mem_re = acc && is_rd && in_ram && ram_en_reg && !bank_is_clock && !ram_none;
    assign mem_we = acc && is_wr && in_ram && ram_en_reg && !bank_is_clock && !ram_none;

    // ROM offset: bank 0 fixed in the low half, the selected bank in the high half,
    // masked to the ROM size (sizes above 2 MiB behave as 2 MiB).
    assign rom_lg      = (rom_size_reg > ROM_LOG2_MAX) ? ROM_LOG2_MAX : rom_size_reg;
    assign rom_sel_eff = req.address[14] ? rom_sel_reg : 7'd0;
    assign rom_raw     = {rom_sel_eff, req.address[13:0]};
    assign rom_mask    = (22'd1 << rom_lg) - 22'd1;

    // Clock commands. Only one of them can be active for a given request.
    always_comb
    begin
        rtc_cmd.tick     = acc && is_tick && rtc_present_reg;
        rtc_cmd.reg_wr   = acc && is_wr && in_ram && ram_en_reg && bank_is_clock && clock_ok;
        rtc_cmd.latch_wr = acc && is_wr && in_rom && rtc_present_reg
                         && (req.address[14:13] == CTL_LATCH);
        rtc_cmd.sel      = ram_sel_reg[2:0];
        rtc_cmd.wdata    = req.data;
    end

    // Response of the request being accepted.
    always_comb
    begin
        dec.use_mem        = mem_re;
        dec.res.read_data  = is_rd ? BYTE_OPEN : 8'd0;
        dec.res.rom_read   = is_rd && in_rom;
        dec.res.rom_offset = (is_rd && in_rom) ? (rom_raw & rom_mask[20:0]) : 21'd0;
        if (is_rd && in_ram && ram_en_reg && bank_is_clock && clock_ok)
        begin
            dec.res.read_data = rtc_byte;
        end
    end

    // Control register writes below 0x8000.
    always_comb
    begin
        ram_en_next  = ram_en_reg;
        rom_sel_next = rom_sel_reg;
        ram_sel_next = ram_sel_reg;
        if (acc && is_wr && in_rom)
        begin
            unique case (req.address[14:13])
                CTL_RAM_EN:   ram_en_next  = (req.data[3:0] == RAM_EN_KEY);
                CTL_ROM_BANK: rom_sel_next = (req.data[6:0] == 7'd0) ? 7'd1 : req.data[6:0];
                CTL_RAM_BANK: ram_sel_next = req.data;
                CTL_LATCH: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_en_reg   <= 1'b0;
            rom_sel_reg  <= 7'd1;
            ram_sel_reg  <= 8'd0;
            fl_valid_reg <= 1'b0;
        end
        else
        begin
            ram_en_reg   <= ram_en_next;
            rom_sel_reg  <= rom_sel_next;
            ram_sel_reg  <= ram_sel_next;
            fl_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fl_reg <= dec;
        end
    end

    // ------------------------------------------------------------------
    // Storage and clock.
    // ------------------------------------------------------------------
    cbm_ram #(
        .DEPTH (RAM_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (ram_addr),
        .wdata (req.data),
        .rdata (mem_rdata)
    );

    cbm_rtc u_rtc (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rtc_cmd),
        .rd_byte (rtc_byte)
    );

    // ------------------------------------------------------------------
    // Result queue. A request in flight always finds room, because a new request
    // is accepted only while queue entries plus the one in flight leave a slot.
    // The stall depends on registers alone, so the response side never reaches
    // the request side through combinational logic.
    // ------------------------------------------------------------------
    always_comb
    begin
        q_push_data = fl_reg.res;
        if (fl_reg.use_mem)
        begin
            q_push_data.read_data = mem_rdata;
        end
    end

    assign req_stall = ({1'b0, q_count} + (CW + 1)'(fl_valid_reg)) > (CW + 1)'(OUTQ_DEPTH - 1);

    cbm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fl_valid_reg),
        .push_data (q_push_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .count     (q_count)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The request in flight must never land in a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fl_valid_reg |-> (q_count != CW'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    // The ROM bank register can never hold bank zero.
    a_rom_sel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_sel_reg != 7'd0)
        else $error("ROM bank register holds zero");

    // ROM reads carry open-bus data; other responses carry no ROM offset.
    a_rom_read_open: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.rom_read) |-> (rsp.read_data == BYTE_OPEN))
        else $error("ROM read with data other than open bus");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.rom_read) |-> (rsp.rom_offset == 21'd0))
        else $error("ROM offset on a response that is not a ROM read");

endmodule

`default_nettype wire

### dv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the cartridge bank mapper with real-time clock.
// Bus reads, bus writes and clock ticks go in on the request channel. A
// behavioral mapper model inside the bench predicts every response, and each
// response is checked field by field in order. Directed sequences come first:
// address extremes, bank selects and a clock rollover into the day carry.
// Random traffic follows under twelve register settings and three idle
// profiles. Every register is written and read back over the APB port.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RAM_CAP       = RAM_BYTES_DEF;
    localparam int          DRAIN_SETTLE  = 4;
    localparam int          PHASE_ITEMS   = 85;
    localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
    localparam int unsigned CLOCK_WRAP    = 512 * SECS_PER_DAY;
    localparam int unsigned BANK_SPAN     = 32'h2000;
    localparam int unsigned ROM_BANK_SPAN = 32'h4000;
    localparam logic [15:0] ROM_END       = 16'h8000;
    localparam logic [15:0] RAM_BASE      = 16'hA000;
    localparam logic [15:0] RAM_END       = 16'hC000;
    localparam logic [7:0]  RTC_SEL_FIRST = 8'd8;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input has a known
    // value from time zero.
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cartridge_bank_mapper_with_rtc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Mapper model: configuration, control registers, the banked RAM and the
    // real-time clock. It is advanced once per request, in request order.
    // ------------------------------------------------------------------------
    logic [4:0]  cfg_rom_log2;
    logic [2:0]  cfg_ram_code;
    logic        cfg_rtc;

    logic [7:0]  cart_ram [RAM_CAP];
    bit          ram_written [RAM_CAP];
    logic        ram_en;
    logic [6:0]  rom_sel;
    logic [7:0]  ram_sel;
    logic        latch_q;
    int unsigned clk_sec;
    int unsigned clk_min;
    int unsigned clk_hour;
    int unsigned clk_day;
    logic        clk_halt;
    logic        clk_carry;
    logic [7:0]  latched [5];

    rsp_t        expected_rsps [$];
    rsp_t        oldest_expected;
    int          error_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    function automatic void reset_mapper_model();
        cfg_rom_log2 = ROM_LOG2_MAX;
        cfg_ram_code = RAM_CODE_32K;
        cfg_rtc      = 1'b1;
        ram_en       = 1'b0;
        rom_sel      = 7'd1;
        ram_sel      = 8'd0;
        latch_q      = 1'b0;
        clk_sec      = 0;
        clk_min      = 0;
        clk_hour     = 0;
        clk_day      = 0;
        clk_halt     = 1'b0;
        clk_carry    = 1'b0;
        foreach (latched[i]) latched[i] = 8'h00;
        foreach (ram_written[i]) ram_written[i] = 1'b0;
    endfunction

    // Usable RAM size for the current size code; code 0 and codes past 64 KiB mean
    // no RAM, and the size never exceeds what the block was built with.
    function automatic int unsigned ram_bytes();
        int unsigned sz;
        case (cfg_ram_code)
            RAM_CODE_2K:  sz = 2048;
            RAM_CODE_8K:  sz = 8192;
            RAM_CODE_32K: sz = 32768;
            RAM_CODE_64K: sz = 65536;
            default:      sz = 0;
        endcase
        if (sz > RAM_CAP) sz = RAM_CAP;
        return sz;
    endfunction

    // The bank offset wraps modulo the usable size, so high bank numbers alias.
    function automatic int unsigned ram_slot(input logic [15:0] a, input int unsigned sz);
        return (int'(ram_sel) * BANK_SPAN + int'(a) - int'(RAM_BASE)) % sz;
    endfunction

    function automatic bit rtc_selected();
        return cfg_rtc && ram_sel >= RTC_SEL_FIRST && ram_sel <= RTC_SEL_LAST;
    endfunction

    function automatic void capture_clock();
        latched[RTC_SEC]  = clk_sec[7:0];
        latched[RTC_MIN]  = clk_min[7:0];
        latched[RTC_HOUR] = clk_hour[7:0];
        latched[RTC_DAYL] = clk_day[7:0];
        latched[RTC_DAYH] = {clk_carry, clk_halt, 5'd0, clk_day[8]};
    endfunction

    // One second forward. Out-of-range fields are folded in through the total
    // second count, and running past day 511 sets the sticky carry.
    function automatic void advance_clock();
        int unsigned total;
        if (clk_halt) return;
        total = clk_sec + 60 * clk_min + 3600 * clk_hour + SECS_PER_DAY * clk_day + 1;
        if (total >= CLOCK_WRAP) clk_carry = 1'b1;
        total    = total % CLOCK_WRAP;
        clk_day  = total / SECS_PER_DAY;
        total    = total % SECS_PER_DAY;
        clk_hour = total / 3600;
        total    = total % 3600;
        clk_min  = total / 60;
        clk_sec  = total % 60;
    endfunction

    function automatic void write_clock_reg(input logic [7:0] d);
        logic [2:0] reg_sel;
        reg_sel = 3'(ram_sel - RTC_SEL_FIRST);
        case (reg_sel)
            RTC_SEC:  clk_sec  = d[5:0];
            RTC_MIN:  clk_min  = d[5:0];
            RTC_HOUR: clk_hour = d[4:0];
            RTC_DAYL: clk_day  = (clk_day & 32'h100) | d;
            RTC_DAYH:
            begin
                clk_day   = (clk_day & 32'hFF) | (int'(d[0]) << 8);
                clk_halt  = d[6];
                clk_carry = d[7];
            end
            default: ;
        endcase
    endfunction

    function automatic void control_write(input logic [15:0] a, input logic [7:0] d);
        case (a[14:13])
            CTL_RAM_EN:   ram_en  = (d[3:0] == RAM_EN_KEY);
            CTL_ROM_BANK: rom_sel = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
            CTL_RAM_BANK: ram_sel = d;
            CTL_LATCH:
            begin
                // The latch copies the clock only on a 0 to 1 edge of bit 0.
                if (cfg_rtc)
                begin
                    if (!latch_q && d[0]) capture_clock();
                    latch_q = d[0];
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] ram_read_byte(input logic [15:0] a);
        int unsigned sz;
        if (!ram_en) return BYTE_OPEN;
        if (ram_sel >= RTC_SEL_FIRST)
            return rtc_selected() ? latched[ram_sel - RTC_SEL_FIRST] : BYTE_OPEN;
        sz = ram_bytes();
        if (sz == 0) return BYTE_OPEN;
        return cart_ram[ram_slot(a, sz)];
    endfunction

    function automatic void ram_write_byte(input logic [15:0] a, input logic [7:0] d);
        int unsigned sz;
        int unsigned slot;
        if (!ram_en) return;
        if (ram_sel >= RTC_SEL_FIRST)
        begin
            if (rtc_selected()) write_clock_reg(d);
            return;
        end
        sz = ram_bytes();
        if (sz == 0) return;
        slot = ram_slot(a, sz);
        cart_ram[slot]    = d;
        ram_written[slot] = 1'b1;
    endfunction

    function automatic bit in_ram_window(input logic [15:0] a);
        return a >= RAM_BASE && a < RAM_END;
    endfunction

    // True when a read would fetch a RAM byte that was never written; the
    // bench turns such reads into writes so that it never asks for one.
    function automatic bit reads_unwritten_ram(input req_t r);
        int unsigned sz;
        if (r.mode != MODE_READ || !in_ram_window(r.address)) return 1'b0;
        if (!ram_en || ram_sel >= RTC_SEL_FIRST) return 1'b0;
        sz = ram_bytes();
        if (sz == 0) return 1'b0;
        return !ram_written[ram_slot(r.address, sz)];
    endfunction

    // Response for one request, with the model state moved past it.
    function automatic rsp_t predict_response(input req_t r);
        rsp_t        o;
        int unsigned lg;
        int unsigned bank;
        o = '0;
        case (r.mode)
            MODE_READ:
            begin
                if (r.address < ROM_END)
                begin
                    // Sizes above the largest ROM act as the largest ROM.
                    lg   = (cfg_rom_log2 > ROM_LOG2_MAX) ? ROM_LOG2_MAX : cfg_rom_log2;
                    bank = (r.address < ROM_BANK_SPAN) ? 0 : rom_sel;
                    o.rom_offset = 21'((bank * ROM_BANK_SPAN + r.address[13:0])
                                       & ((32'd1 << lg) - 32'd1));
                    o.rom_read   = 1'b1;
                    o.read_data  = BYTE_OPEN;
                end
                else if (in_ram_window(r.address))
                    o.read_data = ram_read_byte(r.address);
                else
                    o.read_data = BYTE_OPEN;
            end
            MODE_WRITE:
            begin
                if (r.address < ROM_END)
                    control_write(r.address, r.data);
                else if (in_ram_window(r.address))
                    ram_write_byte(r.address, r.data);
            end
            MODE_TICK:
            begin
                if (cfg_rtc) advance_clock();
            end
            default: ;
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Response side: random stall, and an in-order check of every response
    // against the oldest prediction. Sampling at the edge sees the values that
    // were stable before it.
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                error_count++;
                $display("%0t: response with nothing expected, expected none, actual %h",
                         $time, rsp);
            end
            else
            begin
                oldest_expected = expected_rsps.pop_front();
                if (rsp.read_data !== oldest_expected.read_data)
                    report_field("read_data", oldest_expected.read_data, rsp.read_data);
                if (rsp.rom_read !== oldest_expected.rom_read)
                    report_field("rom_read", oldest_expected.rom_read, rsp.rom_read);
                if (rsp.rom_offset !== oldest_expected.rom_offset)
                    report_field("rom_offset", oldest_expected.rom_offset, rsp.rom_offset);
            end
        end
    end

    // A stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side. All tasks return right after a rising edge, so each one may
    // drive its first values at once.
    // ------------------------------------------------------------------------
    function automatic req_t make_req(input mode_t m, input logic [15:0] a,
                                      input logic [7:0] d);
        req_t r;
        r.mode    = m;
        r.address = a;
        r.data    = d;
        return r;
    endfunction

    // Sends one request after an optional random gap. The prediction is queued
    // before the request is offered; its response cannot appear before the
    // request has been taken.
    task automatic send_request(input req_t item);
        req_t sent;
        rsp_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        sent = item;
        if (reads_unwritten_ram(sent)) sent.mode = MODE_WRITE;
        predicted = predict_response(sent);
        expected_rsps.insert(expected_rsps.size(), predicted);
        req_valid <= 1'b1;
        req       <= sent;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // Holds back new requests until every response is in, then lets the block settle.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Writes one register in a setup and an access phase, then reads it back.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            CFG_ROM_SIZE:
            begin
                cfg_rom_log2 = value[4:0];
                stored       = {27'd0, cfg_rom_log2};
            end
            CFG_RAM_SIZE:
            begin
                cfg_ram_code = value[2:0];
                stored       = {29'd0, cfg_ram_code};
            end
            default:
            begin
                cfg_rtc = value[0];
                stored  = {31'd0, cfg_rtc};
            end
        endcase
        if (readback !== stored) report_field("register readback", stored, readback);
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [4:0] rom_log2, input logic [2:0] ram_code,
                                input logic rtc_on);
        wait_for_responses();
        write_register(CFG_ROM_SIZE, {27'd0, rom_log2});
        write_register(CFG_RAM_SIZE, {29'd0, ram_code});
        write_register(CFG_RTC, {31'd0, rtc_on});
    endtask

    // Twelve settings that cover the size extremes, sizes past the legal range,
    // and the clock both present and absent.
    task automatic apply_sweep_setting(input int n);
        case (n)
            0:  apply_config(5'd21, 3'd3, 1'b1);
            1:  apply_config(5'd15, 3'd0, 1'b1);
            2:  apply_config(5'd21, 3'd4, 1'b0);
            3:  apply_config(5'd31, 3'd1, 1'b1);
            4:  apply_config(5'd0,  3'd2, 1'b1);
            5:  apply_config(5'd18, 3'd7, 1'b0);
            6:  apply_config(5'd16, 3'd4, 1'b1);
            7:  apply_config(5'd21, 3'd1, 1'b0);
            8:  apply_config(5'd15, 3'd3, 1'b1);
            9:  apply_config(5'd20, 3'd2, 1'b1);
            10: apply_config(5'd17, 3'd0, 1'b0);
            default: apply_config(5'd21, 3'd4, 1'b1);
        endcase
    endtask

    // RAM window addresses cluster on a few offsets at both ends of the bank so
    // that reads mostly find bytes written earlier.
    function automatic logic [15:0] ram_address();
        logic [12:0] offset;
        if ($urandom_range(0, 3) != 0)
            offset = 13'($urandom_range(0, 15)) | ($urandom_range(0, 1) ? 13'h1FF0 : 13'h0);
        else
            offset = 13'($urandom_range(0, 13'h1FFF));
        return RAM_BASE + 16'(offset);
    endfunction

    function automatic logic [15:0] unmapped_address();
        if ($urandom_range(0, 1))
            return 16'($urandom_range(16'h8000, 16'h9FFF));
        return 16'($urandom_range(16'hC000, 16'hFFFF));
    endfunction

    // Mostly well-formed traffic: RAM enabled with the key, banks in the
    // populated and clock ranges, clock writes that seldom halt the clock.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned lane;
        r.data    = 8'($urandom);
        r.address = 16'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 45)
        begin
            r.mode = MODE_READ;
            lane   = $urandom_range(0, 9);
            if (lane < 3)
                r.address = 16'($urandom_range(0, 16'h7FFF));
            else if (lane < 9)
                r.address = ram_address();
            else
                r.address = unmapped_address();
        end
        else if (pick < 85)
        begin
            r.mode = MODE_WRITE;
            lane   = $urandom_range(0, 19);
            if (lane < 9)
            begin
                r.address = ram_address();
                if ($urandom_range(0, 3) != 0) r.data[6] = 1'b0;
            end
            else if (lane < 12)
            begin
                r.address = {1'b0, CTL_RAM_EN, 13'($urandom)};
                if ($urandom_range(0, 3) != 0) r.data[3:0] = RAM_EN_KEY;
            end
            else if (lane < 13)
            begin
                r.address = {1'b0, CTL_ROM_BANK, 13'($urandom)};
                if ($urandom_range(0, 9) == 0) r.data = 8'h00;
            end
            else if (lane < 16)
            begin
                r.address = {1'b0, CTL_RAM_BANK, 13'($urandom)};
                pick      = $urandom_range(0, 19);
                if (pick < 10)
                    r.data = 8'($urandom_range(0, 3));
                else if (pick < 17)
                    r.data = 8'($urandom_range(RTC_SEL_FIRST, RTC_SEL_LAST));
            end
            else if (lane < 18)
                r.address = {1'b0, CTL_LATCH, 13'($urandom)};
            else
                r.address = unmapped_address();
        end
        else if (pick < 97)
            r.mode = MODE_TICK;
        else
            r.mode = MODE_NONE;
        return r;
    endfunction

    task automatic run_random_requests(input int count);
        repeat (count) send_request(random_request());
    endtask

    task automatic run_sweep(input int first);
        for (int n = first; n < first + 4; n++)
        begin
            apply_sweep_setting(n);
            run_random_requests(PHASE_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset settings: ROM reads at the window edges, bank zero turning into
    // bank one, the top ROM bank, RAM locked and unlocked, the RAM byte at the
    // very top, unmapped reads, an ignored write and the idle mode.
    task automatic test_mapper_basics();
        send_request(make_req(MODE_READ,  16'h0000, 8'h00));
        send_request(make_req(MODE_READ,  16'h7FFF, 8'hFF));
        send_request(make_req(MODE_WRITE, 16'h2000, 8'h00));
        send_request(make_req(MODE_READ,  16'h4000, 8'h00));
        send_request(make_req(MODE_WRITE, 16'h3FFF, 8'hFF));
        send_request(make_req(MODE_READ,  16'h7FFF, 8'h00));
        send_request(make_req(MODE_READ,  16'hA000, 8'h00));
        send_request(make_req(MODE_WRITE, 16'h1FFF, {4'h5, RAM_EN_KEY}));
        send_request(make_req(MODE_WRITE, 16'h4000, 8'h03));
        send_request(make_req(MODE_WRITE, 16'hBFFF, 8'hFF));
        send_request(make_req(MODE_READ,  16'hBFFF, 8'h00));
        send_request(make_req(MODE_READ,  16'h8000, 8'h00));
        send_request(make_req(MODE_READ,  16'hFFFF, 8'hFF));
        send_request(make_req(MODE_WRITE, 16'hC000, 8'hA5));
        send_request(make_req(MODE_NONE,  16'hFFFF, 8'hFF));
    endtask

    // Day 511 with an out-of-range hour: one tick wraps the day count and sets
    // the carry, and the latched copies of the hour and day-high bytes show it.
    task automatic test_clock_rollover();
        send_request(make_req(MODE_WRITE, 16'h4000, RTC_SEL_FIRST + RTC_DAYH));
        send_request(make_req(MODE_WRITE, 16'hA000, 8'h01));
        send_request(make_req(MODE_WRITE, 16'h4000, RTC_SEL_FIRST + RTC_DAYL));
        send_request(make_req(MODE_WRITE, 16'hBFFF, 8'hFF));
        send_request(make_req(MODE_WRITE, 16'h4000, RTC_SEL_FIRST + RTC_HOUR));
        send_request(make_req(MODE_WRITE, 16'hA123, 8'h1F));
        send_request(make_req(MODE_TICK,  16'h0000, 8'h00));
        send_request(make_req(MODE_WRITE, 16'h6000, 8'h00));
        send_request(make_req(MODE_WRITE, 16'h7FFF, 8'h01));
        send_request(make_req(MODE_READ,  16'hA000, 8'h00));
        send_request(make_req(MODE_WRITE, 16'h4000, RTC_SEL_FIRST + RTC_DAYH));
        send_request(make_req(MODE_READ,  16'hA000, 8'h00));
    endtask

    task automatic test_slow_receiver();
        tx_idle_pct = 18;
        rx_idle_pct = 74;
        run_sweep(0);
    endtask

    task automatic test_slow_sender();
        tx_idle_pct = 74;
        rx_idle_pct = 18;
        run_sweep(4);
    endtask

    task automatic test_back_to_back();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_sweep(8);
    endtask

    initial
    begin
        reset_mapper_model();
        tx_idle_pct = 18;
        rx_idle_pct = 74;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_mapper_basics();
        test_clock_rollover();
        test_slow_receiver();
        test_slow_sender();
        test_back_to_back();

        // Let the last responses arrive; stray extra responses would still be
        // caught during the settle time.
        wait_for_responses();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
src/cbm_pkg.sv
src/cbm_ram.sv
src/cbm_rtc.sv
src/cbm_outq.sv
src/cartridge_bank_mapper_with_rtc.sv
dv/tb_top.sv
